/* src/plp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plp_pkg
// Shared types, constants and the rounding premultiply for the palette lookup.
// ----------------------------------------------------------------------------
package plp_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CHAN_W          = 8;
    localparam int WORD_W          = 4 * CHAN_W;
    localparam int FIELD_IDX_W     = 8;
    // one bit wider than the index field, so the entry count itself fits
    localparam int CMP_W           = FIELD_IDX_W + 1;
    localparam logic [CMP_W-1:0] ENTRIES_LIMIT = CMP_W'(PALETTE_ENTRIES);

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_RESOLVE = 1'b1;

    typedef struct packed {
        logic                   op;
        logic [FIELD_IDX_W-1:0] entry_index;
        logic [CHAN_W-1:0]      write_red;
        logic [CHAN_W-1:0]      write_green;
        logic [CHAN_W-1:0]      write_blue;
        logic [CHAN_W-1:0]      write_alpha;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
    } t_out_item;

    // read stage: one resolve transaction with its palette word
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;   // alpha 31..24, blue 23..16, green 15..8, red 7..0
    } t_rd_stage;

    // (c*a + 127) / 255 by reciprocal: floor(x/255) = (x + 1 + (x >> 8)) >> 8
    function automatic logic [CHAN_W-1:0] premul(input logic [CHAN_W-1:0] c,
                                                 input logic [CHAN_W-1:0] a);
        logic [2*CHAN_W:0] x;
        logic [2*CHAN_W:0] s;
        x = (2*CHAN_W+1)'(c) * (2*CHAN_W+1)'(a) + (2*CHAN_W+1)'(127);
        s = x + (2*CHAN_W+1)'(1) + (x >> CHAN_W);
        return s[2*CHAN_W-1:CHAN_W];
    endfunction

endpackage
`default_nettype wire

/* src/plp_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plp_store
// Palette memory with registered read and per-entry valid bits.
// ----------------------------------------------------------------------------
module plp_store
    import plp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire logic             i_wr_en,
    input  wire logic             i_rd_en,
    input  wire logic [FIELD_IDX_W-1:0] i_index,
    input  wire logic [WORD_W-1:0] i_wr_word,
    output t_rd_stage             o_rd
);

    logic [WORD_W-1:0]          mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] r_entry_valid;
    logic [WORD_W-1:0]          r_word;
    logic                       r_hit;
    logic                       r_rd_valid;
    logic                       in_range;
    logic [IDX_W-1:0]           addr;

    assign in_range = {1'b0, i_index} < ENTRIES_LIMIT;
    assign addr     = i_index[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr_en && in_range) begin
            mem[addr] <= i_wr_word;
        end
        if (i_rd_en) begin
            r_word <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_rd_valid    <= 1'b0;
            r_hit         <= 1'b0;
        end else begin
            if (i_wr_en && in_range) begin
                r_entry_valid[addr] <= 1'b1;
            end
            if (i_adv) begin
                r_rd_valid <= i_rd_en;
            end
            if (i_rd_en) begin
                r_hit <= in_range && r_entry_valid[addr];
            end
        end
    end

    // unwritten or out-of-range entries read as transparent black
    assign o_rd.valid = r_rd_valid;
    assign o_rd.word  = r_hit ? r_word : '0;

endmodule
`default_nettype wire

/* src/plp_premul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plp_premul
// Premultiplies the looked-up colour by alpha into the output register.
// ----------------------------------------------------------------------------
module plp_premul
    import plp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_adv,
    input  wire t_rd_stage i_rd,
    output logic           o_valid,
    output t_out_item      o_item
);

    logic      r_valid;
    t_out_item r_item;
    t_out_item n_item;
    logic [CHAN_W-1:0] alpha;

    assign alpha = i_rd.word[4*CHAN_W-1:3*CHAN_W];

    always_comb begin
        n_item.out_red   = premul(i_rd.word[CHAN_W-1:0], alpha);
        n_item.out_green = premul(i_rd.word[2*CHAN_W-1:CHAN_W], alpha);
        n_item.out_blue  = premul(i_rd.word[3*CHAN_W-1:2*CHAN_W], alpha);
        n_item.out_alpha = alpha;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_rd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_rd.valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

/* src/palette_lookup_premultiply.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// palette_lookup_premultiply
// Palette lookup turning 8-bit indices into premultiplied RGBA.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_item): a write transaction
// stores one RGBA palette word and gives no result; a resolve transaction
// looks up its index and gives one result on the output channel
// (o_out_valid / i_out_ready / o_out_item).
// Throughput: one transaction per cycle while o_in_ready is high, writes and
// resolves mixed freely. A resolve's result passes through the registered
// palette memory read and then the premultiply into the output register.
// A write is visible to a resolve accepted in the very next cycle.
// Reset clears the per-entry valid bits at once, so every entry reads as
// transparent black; no clearing pass, and the input is ready right away.
// When the receiver stalls, the output and read stages hold; up to two
// results sit in flight and o_in_ready drops once both are occupied.
// Writes are held off too while the pipeline is full.
// ----------------------------------------------------------------------------
module palette_lookup_premultiply
    import plp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_item
);

    t_rd_stage rd;
    logic      adv_out;
    logic      adv_rd;
    logic      acc;
    logic      acc_wr;
    logic      acc_rd;

    assign adv_out    = !o_out_valid || i_out_ready;
    assign adv_rd     = !rd.valid || adv_out;
    assign o_in_ready = adv_rd;
    assign acc        = i_in_valid && o_in_ready;
    assign acc_wr     = acc && (i_in_item.op == OP_WRITE);
    assign acc_rd     = acc && (i_in_item.op == OP_RESOLVE);

    plp_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv_rd),
        .i_wr_en   (acc_wr),
        .i_rd_en   (acc_rd),
        .i_index   (i_in_item.entry_index),
        .i_wr_word ({i_in_item.write_alpha, i_in_item.write_blue,
                     i_in_item.write_green, i_in_item.write_red}),
        .o_rd      (rd)
    );

    plp_premul u_premul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv_out),
        .i_rd    (rd),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

`ifndef SYNTHESIS
    a_full_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd.valid && o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while both stages are stalled");

    a_resolve_enters_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_rd |=> rd.valid)
        else $error("accepted resolve missing from read stage");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_wr |=> !rd.valid)
        else $error("write transaction produced a read stage entry");

    a_premul_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.out_red <= o_out_item.out_alpha &&
                         o_out_item.out_green <= o_out_item.out_alpha &&
                         o_out_item.out_blue <= o_out_item.out_alpha))
        else $error("premultiplied colour exceeds alpha");
`endif

endmodule
`default_nettype wire
